// ===== rtl/core/tcspq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcspq_pkg;

  // Number of cells in the queue.
  localparam int QUEUE_DEPTH = 16;
  // Entry counter width, wide enough to hold QUEUE_DEPTH itself.
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  // Width of the reported occupancy field.
  localparam int OCC_W = 5;

  // Operation codes.
  localparam logic [1:0] OP_INS_KEY   = 2'd0;
  localparam logic [1:0] OP_INS_CLASS = 2'd1;
  localparam logic [1:0] OP_POP       = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        premium;
    logic [31:0] time_key;
    logic [31:0] id_key;
    logic [15:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             popped_valid;
    logic             popped_premium;
    logic [31:0]      popped_time;
    logic [31:0]      popped_id;
    logic [15:0]      popped_payload;
    logic [OCC_W-1:0] occupancy;
    logic             empty_res;
  } out_item_t;

  // One stored queue entry.
  typedef struct packed {
    logic        premium;
    logic [31:0] time_key;
    logic [31:0] id_key;
    logic [15:0] payload;
  } entry_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic   eval;
    logic   ins;
    logic   pop;
    logic   op_class;
    entry_t new_entry;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcspq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcspq_cell (
  input  wire                 clk,
  input  tcspq_pkg::cell_ctl_t ctl,
  input  wire                 occ,
  input  wire                 npseen_in,
  output logic                npseen_out,
  input  wire                 placed_in,
  output logic                placed_out,
  input  tcspq_pkg::entry_t   left_entry,
  input  tcspq_pkg::entry_t   right_entry,
  output tcspq_pkg::entry_t   entry
);
  import tcspq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  logic   stop_r;
  logic   stop_nxt;
  logic   goes_before;
  logic   np_incl;

  assign entry = entry_r;

  // The held entry sorts ahead of the new one by (time, id).
  assign goes_before = (entry_r.time_key < ctl.new_entry.time_key) ||
                       ((entry_r.time_key == ctl.new_entry.time_key) &&
                        (entry_r.id_key < ctl.new_entry.id_key));

  // A standard entry has been seen at or before this cell: the leading
  // premium run has ended.
  assign np_incl    = npseen_in | (occ & ~entry_r.premium);
  assign npseen_out = np_incl;

  // The new entry may stop here; an empty cell always accepts it.
  always_comb begin
    stop_nxt = stop_r;
    if (ctl.eval) begin
      if (!occ) begin
        stop_nxt = 1'b1;
      end else if (!ctl.op_class) begin
        stop_nxt = ~goes_before;
      end else if (ctl.new_entry.premium) begin
        stop_nxt = ~entry_r.premium;
      end else begin
        stop_nxt = np_incl & ~goes_before;
      end
    end
  end

  // The first stopping cell takes the new entry, the ones after it shift right.
  assign placed_out = placed_in | stop_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (placed_in) begin
        entry_nxt = left_entry;
      end else if (stop_r) begin
        entry_nxt = ctl.new_entry;
      end
    end else if (ctl.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    stop_r  <= stop_nxt;
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/two_class_sorted_priority_queue_unit.sv =====
// Steps: an accepted item is held, the compare step registers each cell's key
// compare, and the apply step ripples the insert position down the cell row and
// registers the result; the next item may be taken during the apply step.
// A stalled result keeps its item in the apply cycle, and no new item is taken until it leaves.
// Reset (synchronous, rst_n low) empties the queue and clears both channels.
`timescale 1ns / 1ps
`default_nettype none

module two_class_sorted_priority_queue_unit (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  tcspq_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  wire                   out_ready,
  output tcspq_pkg::out_item_t  out_item
);
  import tcspq_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]       state_r, state_nxt;
  in_item_t         item_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  out_item_t        out_item_r, out_item_nxt;

  logic             slot_free;
  logic             apply;
  logic             accept;
  logic             is_ins;
  logic             is_pop;
  logic             full;
  cell_ctl_t        ctl;

  logic [QUEUE_DEPTH-1:0] occ;
  logic [QUEUE_DEPTH:0]   npseen;
  logic [QUEUE_DEPTH:0]   placed;
  entry_t                 cell_entry [QUEUE_DEPTH];

  // Decode of the held item against the current fill.
  assign full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign is_ins = ((item_r.opcode == OP_INS_KEY) || (item_r.opcode == OP_INS_CLASS)) && !full;
  assign is_pop = (item_r.opcode == OP_POP) && (count_r != '0);

  assign slot_free = !out_valid_r || out_ready;
  assign apply     = (state_r == S_APPLY) && slot_free;
  assign in_ready  = (state_r == S_IDLE) || apply;
  assign accept    = in_valid && in_ready;

  // Control shared by every cell.
  always_comb begin
    ctl.eval                = (state_r == S_EVAL);
    ctl.ins                 = apply && is_ins;
    ctl.pop                 = apply && is_pop;
    ctl.op_class            = (item_r.opcode == OP_INS_CLASS);
    ctl.new_entry.premium   = item_r.premium;
    ctl.new_entry.time_key  = item_r.time_key;
    ctl.new_entry.id_key    = item_r.id_key;
    ctl.new_entry.payload   = item_r.payload;
  end

  assign npseen[0] = 1'b0;
  assign placed[0] = 1'b0;

  // Row of cells, head at index zero.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign occ[i] = (CNT_W'(i) < count_r);

    tcspq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (occ[i]),
      .npseen_in   (npseen[i]),
      .npseen_out  (npseen[i+1]),
      .placed_in   (placed[i]),
      .placed_out  (placed[i+1]),
      .left_entry  ((i == 0) ? ctl.new_entry : cell_entry[(i == 0) ? 0 : i-1]),
      .right_entry ((i == QUEUE_DEPTH-1) ? cell_entry[i]
                                         : cell_entry[(i == QUEUE_DEPTH-1) ? i : i+1]),
      .entry       (cell_entry[i])
    );
  end

  // Next fill count and the result of the step.
  always_comb begin
    count_nxt    = count_r;
    out_item_nxt = out_item_r;
    if (apply) begin
      if (is_ins) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (is_pop) begin
        count_nxt = count_r - CNT_W'(1);
      end
      out_item_nxt.status = ST_OK;
      if ((item_r.opcode == OP_INS_KEY || item_r.opcode == OP_INS_CLASS) && full) begin
        out_item_nxt.status = ST_FULL;
      end else if ((item_r.opcode == OP_POP) && (count_r == '0)) begin
        out_item_nxt.status = ST_EMPTY;
      end
      out_item_nxt.popped_valid   = is_pop;
      out_item_nxt.popped_premium = is_pop & cell_entry[0].premium;
      out_item_nxt.popped_time    = is_pop ? cell_entry[0].time_key : '0;
      out_item_nxt.popped_id      = is_pop ? cell_entry[0].id_key : '0;
      out_item_nxt.popped_payload = is_pop ? cell_entry[0].payload : '0;
      out_item_nxt.occupancy      = OCC_W'(count_nxt);
      out_item_nxt.empty_res      = (count_nxt == '0);
    end
  end

  // Sequencer: compare cycle, then apply cycle.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (apply) state_nxt = accept ? S_EVAL : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (apply) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_item;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The fill count never passes the number of cells.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // A successful pop removes exactly one entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    (apply && is_pop) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pop did not decrement count");

  // The compare cycle only ever follows an accepted item.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> $past(in_valid && in_ready))
    else $error("compare cycle without an accepted item");

endmodule

`default_nettype wire

// ===== bench/tcspq_result_checker.sv =====
`timescale 1ns / 1ps

module tcspq_result_checker (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_ready,
  input  tcspq_pkg::in_item_t  in_item,
  input  wire                  out_valid,
  input  wire                  out_ready,
  input  tcspq_pkg::out_item_t out_item,
  output int unsigned          fail_count,
  output int unsigned          pending
);
  import tcspq_pkg::*;

  // Only the first few mismatches are printed; all of them are counted.
  localparam int PRINT_LIMIT = 40;

  // Shadow copy of the queue contents, head first.
  entry_t      shadow_entries[$];
  // Results still owed by the block, oldest first.
  out_item_t   expected_results[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("%0t: result %0d: %s", $time, results_seen, msg);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
    end
  endtask

  // Apply one item to the shadow queue and work out the result it yields.
  task automatic predict_queue_op(input in_item_t it, output out_item_t res);
    int          pos;
    int unsigned held;
    entry_t      fresh;
    res = '0;
    case (it.opcode)
      OP_INS_KEY, OP_INS_CLASS: begin
        if (shadow_entries.size() >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          pos = 0;
          // A class insert first skips the premium entries at the head.
          if (it.opcode == OP_INS_CLASS) begin
            while (pos < shadow_entries.size() && shadow_entries[pos].premium) pos++;
          end
          // Key order applies unless this is a premium class insert; ties go ahead.
          if (it.opcode == OP_INS_KEY || !it.premium) begin
            while (pos < shadow_entries.size() &&
                   (shadow_entries[pos].time_key < it.time_key ||
                    (shadow_entries[pos].time_key == it.time_key &&
                     shadow_entries[pos].id_key < it.id_key))) pos++;
          end
          fresh.premium  = it.premium;
          fresh.time_key = it.time_key;
          fresh.id_key   = it.id_key;
          fresh.payload  = it.payload;
          shadow_entries.insert(pos, fresh);
        end
      end
      OP_POP: begin
        if (shadow_entries.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          fresh = shadow_entries.pop_front();
          res.popped_valid   = 1'b1;
          res.popped_premium = fresh.premium;
          res.popped_time    = fresh.time_key;
          res.popped_id      = fresh.id_key;
          res.popped_payload = fresh.payload;
        end
      end
      default: begin
        // The unused opcode leaves the queue alone.
      end
    endcase
    held = shadow_entries.size();
    res.occupancy = held[OCC_W-1:0];
    res.empty_res = (held == 0);
  endtask

  // Predict on every accepted item and check every accepted result.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      shadow_entries.delete();
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_queue_op(in_item, want);
        expected_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          want = expected_results.pop_front();
          compare_field("status", out_item.status, want.status);
          compare_field("popped_valid", out_item.popped_valid, want.popped_valid);
          compare_field("popped_premium", out_item.popped_premium, want.popped_premium);
          compare_field("popped_time", out_item.popped_time, want.popped_time);
          compare_field("popped_id", out_item.popped_id, want.popped_id);
          compare_field("popped_payload", out_item.popped_payload, want.popped_payload);
          compare_field("occupancy", out_item.occupancy, want.occupancy);
          compare_field("empty_res", out_item.empty_res, want.empty_res);
        end
      end
    end
    fail_count <= mismatches;
    pending <= expected_results.size();
  end

endmodule

// ===== bench/two_class_sorted_priority_queue_unit_tb.sv =====
`timescale 1ns / 1ps

module two_class_sorted_priority_queue_unit_tb;
  import tcspq_pkg::*;

  // The fourth opcode is unused by the block and must be ignored.
  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam int RANDOM_ITEMS = 900;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  int unsigned fail_count;
  int unsigned pending;

  // Every item to be sent, directed ones first.
  in_item_t queue_ops[$];

  int ready_mode = 0;
  int ready_left = 0;
  int ready_tick = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  two_class_sorted_priority_queue_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  tcspq_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic in_item_t op_item(input logic [1:0] op, input logic prem,
                                       input logic [31:0] t, input logic [31:0] id,
                                       input logic [15:0] pl);
    in_item_t it;
    it.opcode   = op;
    it.premium  = prem;
    it.time_key = t;
    it.id_key   = id;
    it.payload  = pl;
    return it;
  endfunction

  // The receiver switches between several stall patterns at random intervals.
  initial out_ready = 1'b0;
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_left <= $urandom_range(16, 96);
    end else begin
      ready_left <= ready_left - 1;
    end
    ready_tick <= ready_tick + 1;
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (ready_tick % 4 == 0);
      default: out_ready <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // Give up if the run hangs.
  initial begin
    #3_000_000;
    $display("** two_class_sorted_priority_queue_unit: FAILED **");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int       burst_left;
    int       n_random;
    int       phase_left;
    int       insert_pct;
    int       roll;
    in_item_t it;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;

    // Directed part: empty queue cases, key extremes, ties and class ordering.
    queue_ops.push_back(op_item(OP_POP, 1'b0, 32'h0, 32'h0, 16'h0));
    queue_ops.push_back(op_item(OP_IGNORED, 1'b1, 32'hffffffff, 32'hffffffff, 16'hffff));
    queue_ops.push_back(op_item(OP_INS_KEY, 1'b1, 32'd5, 32'd5, 16'hffff));
    queue_ops.push_back(op_item(OP_INS_KEY, 1'b0, 32'd5, 32'd5, 16'h0001));
    queue_ops.push_back(op_item(OP_INS_KEY, 1'b0, 32'h0, 32'h0, 16'h0));
    queue_ops.push_back(op_item(OP_INS_KEY, 1'b0, 32'hffffffff, 32'hffffffff, 16'hffff));
    queue_ops.push_back(op_item(OP_INS_KEY, 1'b0, 32'd5, 32'hffffffff, 16'h1234));
    queue_ops.push_back(op_item(OP_INS_CLASS, 1'b1, 32'hffffffff, 32'hffffffff, 16'h00a1));
    queue_ops.push_back(op_item(OP_INS_CLASS, 1'b1, 32'h0, 32'h0, 16'h00a2));
    queue_ops.push_back(op_item(OP_INS_CLASS, 1'b0, 32'd5, 32'd5, 16'h00b1));
    queue_ops.push_back(op_item(OP_INS_CLASS, 1'b0, 32'h0, 32'h0, 16'h00b2));
    queue_ops.push_back(op_item(OP_IGNORED, 1'b0, 32'd7, 32'd7, 16'h5555));
    repeat (10) queue_ops.push_back(op_item(OP_POP, 1'b0, 32'h0, 32'h0, 16'h0));

    // Random part in phases that lean towards filling, churning or draining.
    n_random   = 0;
    phase_left = 0;
    insert_pct = 50;
    while (n_random < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 100);
        case ($urandom_range(0, 2))
          0: insert_pct = 90;
          1: insert_pct = 50;
          default: insert_pct = 15;
        endcase
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      it.premium = 1'($urandom_range(0, 1));
      it.payload = 16'($urandom);
      // Narrow keys half the time so that ties are common.
      if ($urandom_range(0, 1)) begin
        it.time_key = $urandom_range(0, 3);
        it.id_key   = $urandom_range(0, 3);
      end else begin
        it.time_key = $urandom;
        it.id_key   = $urandom;
      end
      if (roll < 2) begin
        it.opcode = OP_IGNORED;
      end else if (roll < insert_pct) begin
        it.opcode = $urandom_range(0, 1) ? OP_INS_CLASS : OP_INS_KEY;
      end else begin
        it.opcode = OP_POP;
      end
      queue_ops.push_back(it);
      n_random++;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Send in bursts of random length separated by short gaps.
    burst_left = 0;
    foreach (queue_ops[k]) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 12);
      end
      in_valid <= 1'b1;
      in_item  <= queue_ops[k];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      burst_left--;
    end
    in_valid <= 1'b0;

    // Drain the outstanding results, then wait a little longer for strays.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("** two_class_sorted_priority_queue_unit: PASSED **");
    end else begin
      $display("** two_class_sorted_priority_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tcspq_pkg.sv
rtl/core/tcspq_cell.sv
rtl/core/two_class_sorted_priority_queue_unit.sv
bench/tcspq_result_checker.sv
bench/two_class_sorted_priority_queue_unit_tb.sv
